// ----- hw/rtl/tccs_pkg.sv -----
package tccs_pkg;

	// screen geometry
	localparam int COLS   = 80;
	localparam int ROWS   = 25;
	localparam int CELLS  = COLS * ROWS;
	localparam int COL_W  = $clog2(COLS);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int ADDR_W = $clog2(CELLS);
	localparam int CELL_W = 16;

	// character codes with a meaning of their own
	localparam logic [7:0] CH_NEWLINE   = 8'd10;
	localparam logic [7:0] CH_BACKSPACE = 8'd8;

	// attribute after reset
	localparam logic [7:0] ATTR_RESET = 8'd15;

	typedef enum logic [1:0] {
		CMD_PUT   = 2'd0,
		CMD_SET   = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_READ  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_CLEAR,
		ST_COPY,
		ST_ZERO,
		ST_RDWAIT,
		ST_DONE
	} state_t;

	// one request, coordinates already clamped
	typedef struct packed {
		cmd_t             cmd;
		logic [7:0]       chr;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
	} req_t;

	// one result
	typedef struct packed {
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic             scrolled;
		logic [7:0]       rchar;
		logic [7:0]       rattr;
	} res_t;

	// sequencer status towards the handshake logic
	typedef struct packed {
		logic ready;
		logic done;
	} seq_stat_t;

	// store access for one cycle
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [CELL_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_ctl_t;

	function automatic logic [COL_W-1:0] clamp_col(input logic signed [15:0] v);
		logic [COL_W-1:0] r;
		if (v < 0) begin
			r = '0;
		end else if (int'(v) >= COLS) begin
			r = COL_W'(COLS - 1);
		end else begin
			r = COL_W'(v);
		end
		return r;
	endfunction

	function automatic logic [ROW_W-1:0] clamp_row(input logic signed [15:0] v);
		logic [ROW_W-1:0] r;
		if (v < 0) begin
			r = '0;
		end else if (int'(v) >= ROWS) begin
			r = ROW_W'(ROWS - 1);
		end else begin
			r = ROW_W'(v);
		end
		return r;
	endfunction

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
		input logic [COL_W-1:0] c);
		return ADDR_W'(int'(r) * COLS + int'(c));
	endfunction

endpackage

// ----- hw/rtl/tccs_store.sv -----
module tccs_store (
	input  logic                              clk,
	input  tccs_pkg::mem_ctl_t                ctl,
	output logic [tccs_pkg::CELL_W-1:0]       rd_data
);

	logic [tccs_pkg::CELL_W-1:0] mem_q [tccs_pkg::CELLS];
	logic [tccs_pkg::CELL_W-1:0] rd_q;

	// one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem_q[ctl.waddr] <= ctl.wdata;
		end
		if (ctl.re) begin
			rd_q <= mem_q[ctl.raddr];
		end
	end

	assign rd_data = rd_q;

endmodule

// ----- hw/rtl/tccs_seq.sv -----
module tccs_seq (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  tccs_pkg::req_t              req,
	input  logic [7:0]                  attr,
	input  logic                        take,
	output tccs_pkg::seq_stat_t         stat,
	output tccs_pkg::res_t              res,
	output tccs_pkg::mem_ctl_t          ctl,
	input  logic [tccs_pkg::CELL_W-1:0] rd_data
);

	tccs_pkg::state_t state_q, state_d;
	tccs_pkg::req_t   req_q;

	logic [tccs_pkg::COL_W-1:0]  col_q;
	logic [tccs_pkg::ROW_W-1:0]  row_q;
	logic [tccs_pkg::ADDR_W-1:0] cnt_q;
	logic [tccs_pkg::ADDR_W-1:0] wr_addr_q;
	logic                        wr_pend_q;
	logic                        scrolled_q;
	logic [7:0]                  rchar_q;
	logic [7:0]                  rattr_q;

	logic is_nl, is_bs, col_last, row_last, wrap, scroll, cnt_last;
	logic [tccs_pkg::ADDR_W-1:0] cnt_inc;

	// decode of the current request against the cursor
	assign is_nl    = (req_q.chr == tccs_pkg::CH_NEWLINE);
	assign is_bs    = (req_q.chr == tccs_pkg::CH_BACKSPACE);
	assign col_last = (int'(col_q) == tccs_pkg::COLS - 1);
	assign row_last = (int'(row_q) == tccs_pkg::ROWS - 1);
	assign wrap     = (req_q.cmd == tccs_pkg::CMD_PUT) && (is_nl || (!is_bs && col_last));
	assign scroll   = wrap && row_last;
	assign cnt_last = (int'(cnt_q) == tccs_pkg::CELLS - 1);

	// shared sweep counter step
	assign cnt_inc = tccs_pkg::ADDR_W'(cnt_q + 1'b1);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tccs_pkg::ST_INIT: begin
				if (cnt_last) state_d = tccs_pkg::ST_IDLE;
			end
			tccs_pkg::ST_IDLE: begin
				if (start) state_d = tccs_pkg::ST_EXEC;
			end
			tccs_pkg::ST_EXEC: begin
				unique case (req_q.cmd)
					tccs_pkg::CMD_PUT:   state_d = scroll ? tccs_pkg::ST_COPY : tccs_pkg::ST_DONE;
					tccs_pkg::CMD_SET:   state_d = tccs_pkg::ST_DONE;
					tccs_pkg::CMD_CLEAR: state_d = tccs_pkg::ST_CLEAR;
					tccs_pkg::CMD_READ:  state_d = tccs_pkg::ST_RDWAIT;
					default:             state_d = tccs_pkg::ST_DONE;
				endcase
			end
			tccs_pkg::ST_CLEAR: begin
				if (cnt_last) state_d = tccs_pkg::ST_DONE;
			end
			tccs_pkg::ST_COPY: begin
				if (cnt_last) state_d = tccs_pkg::ST_ZERO;
			end
			tccs_pkg::ST_ZERO: begin
				if (!wr_pend_q && cnt_last) state_d = tccs_pkg::ST_DONE;
			end
			tccs_pkg::ST_RDWAIT: begin
				state_d = tccs_pkg::ST_DONE;
			end
			tccs_pkg::ST_DONE: begin
				if (take) state_d = tccs_pkg::ST_IDLE;
			end
			default: state_d = tccs_pkg::ST_IDLE;
		endcase
	end

	// store access and status
	always_comb begin
		ctl = '0;
		unique case (state_q) inside
			tccs_pkg::ST_INIT, tccs_pkg::ST_CLEAR: begin
				ctl.we    = 1'b1;
				ctl.waddr = cnt_q;
			end
			tccs_pkg::ST_EXEC: begin
				if (req_q.cmd == tccs_pkg::CMD_PUT && !is_nl && !is_bs) begin
					ctl.we    = 1'b1;
					ctl.waddr = tccs_pkg::cell_addr(row_q, col_q);
					ctl.wdata = {attr, req_q.chr};
				end
				if (req_q.cmd == tccs_pkg::CMD_READ) begin
					ctl.re    = 1'b1;
					ctl.raddr = tccs_pkg::cell_addr(req_q.row, req_q.col);
				end
			end
			tccs_pkg::ST_COPY: begin
				ctl.re    = 1'b1;
				ctl.raddr = cnt_q;
				ctl.we    = wr_pend_q;
				ctl.waddr = wr_addr_q;
				ctl.wdata = rd_data;
			end
			tccs_pkg::ST_ZERO: begin
				ctl.we = 1'b1;
				if (wr_pend_q) begin
					ctl.waddr = wr_addr_q;
					ctl.wdata = rd_data;
				end else begin
					ctl.waddr = cnt_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign stat.ready = (state_q == tccs_pkg::ST_IDLE);
	assign stat.done  = (state_q == tccs_pkg::ST_DONE);

	assign res.col      = col_q;
	assign res.row      = row_q;
	assign res.scrolled = scrolled_q;
	assign res.rchar    = rchar_q;
	assign res.rattr    = rattr_q;

	// state, cursor and sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= tccs_pkg::ST_INIT;
			col_q     <= '0;
			row_q     <= '0;
			cnt_q     <= '0;
			wr_pend_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q) inside
				tccs_pkg::ST_INIT, tccs_pkg::ST_CLEAR: begin
					cnt_q <= cnt_inc;
				end
				tccs_pkg::ST_EXEC: begin
					unique case (req_q.cmd)
						tccs_pkg::CMD_PUT: begin
							if (wrap) begin
								col_q <= '0;
								if (!row_last) row_q <= tccs_pkg::ROW_W'(row_q + 1'b1);
								cnt_q     <= tccs_pkg::ADDR_W'(tccs_pkg::COLS);
								wr_pend_q <= 1'b0;
							end else if (is_bs) begin
								if (col_q != '0) begin
									col_q <= tccs_pkg::COL_W'(col_q - 1'b1);
								end else if (row_q != '0) begin
									row_q <= tccs_pkg::ROW_W'(row_q - 1'b1);
									col_q <= tccs_pkg::COL_W'(tccs_pkg::COLS - 1);
								end
							end else begin
								col_q <= tccs_pkg::COL_W'(col_q + 1'b1);
							end
						end
						tccs_pkg::CMD_SET: begin
							col_q <= req_q.col;
							row_q <= req_q.row;
						end
						tccs_pkg::CMD_CLEAR: begin
							col_q <= '0;
							row_q <= '0;
							cnt_q <= '0;
						end
						default: begin
						end
					endcase
				end
				tccs_pkg::ST_COPY: begin
					wr_pend_q <= 1'b1;
					if (cnt_last) begin
						cnt_q <= tccs_pkg::ADDR_W'(tccs_pkg::CELLS - tccs_pkg::COLS);
					end else begin
						cnt_q <= cnt_inc;
					end
				end
				tccs_pkg::ST_ZERO: begin
					if (wr_pend_q) begin
						wr_pend_q <= 1'b0;
					end else begin
						cnt_q <= cnt_inc;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// request fields and result payload
	always_ff @(posedge clk) begin
		if (state_q == tccs_pkg::ST_IDLE && start) begin
			req_q      <= req;
			scrolled_q <= 1'b0;
			rchar_q    <= '0;
			rattr_q    <= '0;
		end
		if (state_q == tccs_pkg::ST_EXEC) begin
			scrolled_q <= scroll;
		end
		if (state_q == tccs_pkg::ST_COPY) begin
			wr_addr_q <= tccs_pkg::ADDR_W'(cnt_q - tccs_pkg::ADDR_W'(tccs_pkg::COLS));
		end
		if (state_q == tccs_pkg::ST_RDWAIT) begin
			rchar_q <= rd_data[7:0];
			rattr_q <= rd_data[15:8];
		end
	end

	// the store is left alone between requests
	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tccs_pkg::ST_IDLE || state_q == tccs_pkg::ST_DONE) |-> !ctl.we)
		else $error("store written outside a request");

	// copy writes trail the read sweep by one row and one cell
	a_copy_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tccs_pkg::ST_COPY && wr_pend_q) |->
		(cnt_q == tccs_pkg::ADDR_W'(wr_addr_q + tccs_pkg::ADDR_W'(tccs_pkg::COLS) + 1'b1)))
		else $error("scroll copy address out of step");

	// cursor stays on the screen
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(int'(col_q) < tccs_pkg::COLS) && (int'(row_q) < tccs_pkg::ROWS))
		else $error("cursor off screen");

	// a scroll leaves the cursor on the bottom row
	a_scroll_row: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tccs_pkg::ST_COPY) |-> (int'(row_q) == tccs_pkg::ROWS - 1) && (col_q == '0))
		else $error("cursor not at bottom left during scroll");

endmodule

// ----- hw/rtl/text_console_cursor_scroll_top.sv -----
// channel   direction  handshake                 payload
// in        sink       in_valid / in_stall       cmd, char_code, col_arg, row_arg
// out       source     out_valid / out_stall     cursor_col, cursor_row, scrolled,
//                                                read_char, read_attr
// cfg       sink       cfg_valid / cfg_ready     cfg_data (text attribute)
//
// put character, set cursor: accept, then EXEC and DONE, then the output register; read cell adds RDWAIT
// clear screen: one cell per cycle through the single write port, sweeping every cell
// scroll: the store sweep copies each row below the top one row up, then zeroes the last
// after reset a zeroing pass over all 2000 cells runs with in_stall high
// one request at a time; a finished result waits in the output register under out_stall
module text_console_cursor_scroll_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [7:0]  char_code,
	input  logic signed [15:0] col_arg,
	input  logic signed [15:0] row_arg,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [6:0]  cursor_col,
	output logic [4:0]  cursor_row,
	output logic        scrolled,
	output logic [7:0]  read_char,
	output logic [7:0]  read_attr,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);

	tccs_pkg::req_t      req;
	tccs_pkg::res_t      res;
	tccs_pkg::seq_stat_t stat;
	tccs_pkg::mem_ctl_t  ctl;

	logic [tccs_pkg::CELL_W-1:0] rd_data;
	logic [7:0] text_attr_q;
	logic       out_valid_q;
	logic [6:0] cursor_col_q;
	logic [4:0] cursor_row_q;
	logic       scrolled_q;
	logic [7:0] read_char_q;
	logic [7:0] read_attr_q;
	logic       start;
	logic       take;

	// request with clamped coordinates
	assign req.cmd = tccs_pkg::cmd_t'(cmd);
	assign req.chr = char_code;
	assign req.col = tccs_pkg::clamp_col(col_arg);
	assign req.row = tccs_pkg::clamp_row(row_arg);

	assign in_stall = !stat.ready;
	assign start    = in_valid && !in_stall;
	assign take     = !out_valid_q || !out_stall;

	// attribute register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_attr_q <= tccs_pkg::ATTR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			text_attr_q <= cfg_data;
		end
	end

	tccs_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.req     (req),
		.attr    (text_attr_q),
		.take    (take),
		.stat    (stat),
		.res     (res),
		.ctl     (ctl),
		.rd_data (rd_data)
	);

	tccs_store u_store (
		.clk     (clk),
		.ctl     (ctl),
		.rd_data (rd_data)
	);

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (stat.done && take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (stat.done && take) begin
			cursor_col_q <= 7'(res.col);
			cursor_row_q <= 5'(res.row);
			scrolled_q   <= res.scrolled;
			read_char_q  <= res.rchar;
			read_attr_q  <= res.rattr;
		end
	end

	assign out_valid  = out_valid_q;
	assign cursor_col = cursor_col_q;
	assign cursor_row = cursor_row_q;
	assign scrolled   = scrolled_q;
	assign read_char  = read_char_q;
	assign read_attr  = read_attr_q;

	// one request in flight: an accept closes the input at once
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("second request taken while one is in progress");

endmodule
